[sv/sts_pkg.sv]
// Shared types and constants of the sorted table ternary search block.
// Depends on nothing; every other file of the block uses it by scoped names.

package sts_pkg;

   localparam int unsigned IndexW = 10;
   localparam int unsigned ValueW = 32;
   localparam int unsigned CountW = 11;

   localparam logic KindWrite  = 1'b0;
   localparam logic KindSearch = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE1,
      ST_PROBE2,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic table_write;
      logic start;
      logic probe1;
      logic probe2;
      logic decide;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic interval_empty;
      logic match;
   } status_type;

endpackage

[sv/sts_table.sv]
// Table memory of the sorted table ternary search block: one write port and
// one read port with registered read data. Depends on sts_pkg.

module sts_table #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [AW-1:0]                         wr_addr,
   input  logic signed [sts_pkg::ValueW-1:0]     wr_data,
   input  logic                                  rd_en,
   input  logic [AW-1:0]                         rd_addr,
   output logic signed [sts_pkg::ValueW-1:0]     rd_data
);

   logic signed [sts_pkg::ValueW-1:0] mem_ff [DEPTH];
   logic signed [sts_pkg::ValueW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sts_datapath.sv]
// Datapath of the sorted table ternary search block: interval bounds, probe
// positions, compare logic, count register and result payload.
// Depends on sts_pkg and sts_table.

module sts_datapath #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sts_pkg::cmd_type                      cmd,
   output sts_pkg::status_type                   status,
   input  logic [sts_pkg::IndexW-1:0]            req_write_index,
   input  logic signed [sts_pkg::ValueW-1:0]     req_write_value,
   input  logic signed [sts_pkg::ValueW-1:0]     req_search_key,
   input  logic                                  csr_write_enable,
   input  logic [sts_pkg::CountW-1:0]            csr_write_data,
   output logic                                  rsp_found,
   output logic [sts_pkg::IndexW-1:0]            rsp_position
);

   localparam int unsigned AW     = $clog2(DEPTH);
   localparam int unsigned PW     = AW + 2;
   localparam int unsigned ShiftW = AW + 2;
   localparam int unsigned ProdW  = AW + ShiftW;
   // Reciprocal of three, rounded up; exact for every span below 2**(ShiftW-1).
   localparam logic [ShiftW-1:0] Recip = ShiftW'(((1 << ShiftW) + 2) / 3);

   logic [sts_pkg::CountW-1:0]          element_count_ff;
   logic signed [sts_pkg::ValueW-1:0]   key_ff, key_in;
   logic signed [PW-1:0]                lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]                       p1_ff, p1_in, p2_ff, p2_in;
   logic signed [sts_pkg::ValueW-1:0]   v1_ff, v1_in;
   logic                                result_found_ff, result_found_in;
   logic [AW-1:0]                       result_pos_ff, result_pos_in;
   logic                                rsp_found_ff;
   logic [sts_pkg::IndexW-1:0]          rsp_position_ff;

   logic [31:0]                         count_ext, n_full, idx_ext, result_pos_ext;
   logic signed [PW-1:0]                hi_start, span;
   logic [AW-1:0]                       diff, third, p1_comb, p2_comb, rd_addr;
   logic [ProdW-1:0]                    product;
   logic signed [sts_pkg::ValueW-1:0]   rd_data;
   logic                                wr_en, match1, match2;
   logic signed [PW-1:0]                p1_s, p2_s;

   assign count_ext = 32'(element_count_ff);
   assign n_full    = (count_ext > 32'(DEPTH)) ? 32'(DEPTH) : count_ext;
   assign hi_start  = $signed(n_full[PW-1:0]) - $signed(PW'(1));

   assign idx_ext = 32'(req_write_index);
   assign wr_en   = cmd.table_write && (idx_ext < 32'(DEPTH));

   // Probe positions: one third of the span in from each end.
   assign span    = hi_ff - lo_ff;
   assign diff    = span[AW-1:0];
   assign product = ProdW'(diff) * ProdW'(Recip);
   assign third   = product[ProdW-1:ShiftW];
   assign p1_comb = lo_ff[AW-1:0] + third;
   assign p2_comb = hi_ff[AW-1:0] - third;

   assign rd_addr = cmd.probe1 ? p1_comb : p2_ff;

   sts_table #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ext[AW-1:0]),
      .wr_data (req_write_value),
      .rd_en   (cmd.probe1 || cmd.probe2),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign match1 = (key_ff == v1_ff);
   assign match2 = (key_ff == rd_data);
   assign p1_s   = $signed(PW'(p1_ff));
   assign p2_s   = $signed(PW'(p2_ff));

   assign status.interval_empty = (lo_ff > hi_ff);
   assign status.match          = match1 || match2;

   always_comb begin
      key_in          = key_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      p1_in           = p1_ff;
      p2_in           = p2_ff;
      v1_in           = v1_ff;
      result_found_in = result_found_ff;
      result_pos_in   = result_pos_ff;
      if (cmd.start) begin
         key_in          = req_search_key;
         lo_in           = '0;
         hi_in           = hi_start;
         result_found_in = 1'b0;
         result_pos_in   = '0;
      end
      if (cmd.probe1) begin
         p1_in = p1_comb;
         p2_in = p2_comb;
      end
      if (cmd.probe2) begin
         v1_in = rd_data;
      end
      if (cmd.decide) begin
         if (match1) begin
            result_found_in = 1'b1;
            result_pos_in   = p1_ff;
         end else if (match2) begin
            result_found_in = 1'b1;
            result_pos_in   = p2_ff;
         end else if (key_ff < v1_ff) begin
            hi_in = p1_s - $signed(PW'(1));
         end else if (key_ff > rd_data) begin
            lo_in = p2_s + $signed(PW'(1));
         end else begin
            lo_in = p1_s + $signed(PW'(1));
            hi_in = p2_s - $signed(PW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= '0;
      end else if (csr_write_enable) begin
         element_count_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      p1_ff           <= p1_in;
      p2_ff           <= p2_in;
      v1_ff           <= v1_in;
      result_found_ff <= result_found_in;
      result_pos_ff   <= result_pos_in;
   end

   assign result_pos_ext = 32'(result_pos_ff);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_found_ff    <= result_found_ff;
         rsp_position_ff <= result_pos_ext[sts_pkg::IndexW-1:0];
      end
   end

   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // The two probes of a live interval never cross and stay inside it.
   a_probe_order: assert property (@(posedge clock) disable iff (reset)
      cmd.probe1 && !status.interval_empty |=> p1_ff <= p2_ff)
      else $error("probe positions crossed");

   a_probe_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.probe1 && !status.interval_empty |=> p1_s >= lo_ff && p2_s <= hi_ff)
      else $error("probe outside interval");

   // Every round without a match narrows the interval.
   a_interval_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.decide && !status.match |=> span < $past(span))
      else $error("interval did not shrink");

endmodule

[sv/sts_ctrl.sv]
// Controller state machine of the sorted table ternary search block.
// Sequences the probe rounds and owns the result valid. Depends on sts_pkg.

module sts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sts_pkg::status_type   status,
   output sts_pkg::cmd_type      cmd
);

   sts_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sts_pkg::ST_IDLE: begin
            if (req_valid && (req_kind == sts_pkg::KindSearch)) begin
               state_in = sts_pkg::ST_PROBE1;
            end
         end
         sts_pkg::ST_PROBE1: begin
            state_in = status.interval_empty ? sts_pkg::ST_FINISH : sts_pkg::ST_PROBE2;
         end
         sts_pkg::ST_PROBE2: begin
            state_in = sts_pkg::ST_DECIDE;
         end
         sts_pkg::ST_DECIDE: begin
            state_in = status.match ? sts_pkg::ST_FINISH : sts_pkg::ST_PROBE1;
         end
         sts_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = sts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sts_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         sts_pkg::ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.table_write = req_valid && (req_kind == sts_pkg::KindWrite);
            cmd.start       = req_valid && (req_kind == sts_pkg::KindSearch);
         end
         sts_pkg::ST_PROBE1: begin
            cmd.probe1 = 1'b1;
         end
         sts_pkg::ST_PROBE2: begin
            cmd.probe2 = 1'b1;
         end
         sts_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         sts_pkg::ST_FINISH: begin
            cmd.rsp_load = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/sorted_table_ternary_search.sv]
// Sorted table ternary search, top level. A write beat leaves the block idle and
// gives no result. A search runs rounds of two table reads and a compare (at most
// 7 rounds for 1024 entries), then raises rsp_valid; a miss ends with a probe
// state that finds the interval empty. The next beat waits for the block to
// return to idle, and longer while an older result is stalled. Reset clears the
// controller, rsp_valid and element_count, but not the table contents.

module sorted_table_ternary_search #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_kind,
   input  logic [sts_pkg::IndexW-1:0]            req_write_index,
   input  logic signed [sts_pkg::ValueW-1:0]     req_write_value,
   input  logic signed [sts_pkg::ValueW-1:0]     req_search_key,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [sts_pkg::IndexW-1:0]            rsp_position,
   input  logic                                  csr_write_enable,
   input  logic [sts_pkg::CountW-1:0]            csr_write_data
);

   // The controller and datapath talk only through these two bundles.
   sts_pkg::cmd_type    cmd;
   sts_pkg::status_type status;

   // The controller accepts beats only while idle. A write beat goes straight
   // into the table; a search beat launches the probe rounds. The finished
   // result sits in the output register, so a waiting result does not keep
   // the block from taking the next beat.
   sts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the interval bounds, the two probe positions and the
   // table. Each round reads the first probe, then the second, then decides
   // whether to stop or which of the three parts to keep.
   sts_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_write_index  (req_write_index),
      .req_write_value  (req_write_value),
      .req_search_key   (req_search_key),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position)
   );

   // A search beat keeps the block busy on the next cycle.
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == sts_pkg::KindSearch) |=> req_stall)
      else $error("search accepted but block not busy");

   // A miss always reports position zero.
   a_miss_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

endmodule

[test/tb_sorted_table_ternary_search.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_table_ternary_search: table writes and key searches
// go in with random gaps, and each search result is checked against a local prediction.
// Depends on sts_pkg and the sorted_table_ternary_search RTL.

module tb_sorted_table_ternary_search;

   localparam int TableDepth = 1024;
   // Quiet cycles before a register write. A search needs at most seven rounds,
   // and a write beat may still be in flight.
   localparam int SettleCycles = 40;
   localparam int BeatsPerPhase = 20;
   localparam logic signed [sts_pkg::ValueW-1:0] MinValue = 32'sh8000_0000;
   localparam logic signed [sts_pkg::ValueW-1:0] MaxValue = 32'sh7fff_ffff;

   typedef struct packed {
      logic                              kind;
      logic [sts_pkg::IndexW-1:0]        write_index;
      logic signed [sts_pkg::ValueW-1:0] write_value;
      logic signed [sts_pkg::ValueW-1:0] search_key;
   } request_beat_type;

   typedef struct packed {
      logic                       found;
      logic [sts_pkg::IndexW-1:0] position;
   } lookup_result_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic                              req_kind = sts_pkg::KindWrite;
   logic [sts_pkg::IndexW-1:0]        req_write_index = '0;
   logic signed [sts_pkg::ValueW-1:0] req_write_value = '0;
   logic signed [sts_pkg::ValueW-1:0] req_search_key = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_found;
   logic [sts_pkg::IndexW-1:0]        rsp_position;
   logic                              csr_write_enable = 1'b0;
   logic [sts_pkg::CountW-1:0]        csr_write_data = '0;

   // Beats waiting for the driver, and search results waiting for the DUT.
   request_beat_type  request_beats[$];
   lookup_result_type pending_lookups[$];
   request_beat_type  next_beat;
   lookup_result_type expected_hit;

   // Predictor state: the table and the element count as the DUT should hold them.
   logic signed [sts_pkg::ValueW-1:0] shadow_table[TableDepth];
   int                                shadow_count = 0;

   // The stimulus side keeps its own view of the table, since it runs ahead of
   // the beats that the DUT has actually taken.
   logic signed [sts_pkg::ValueW-1:0] plan_table[TableDepth];
   int                                plan_count = 0;

   logic req_fired = 1'b0;
   logic steady_run = 1'b0;
   int   mismatch_count = 0;

   sorted_table_ternary_search #(
      .DEPTH(TableDepth)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_write_index(req_write_index),
      .req_write_value(req_write_value),
      .req_search_key(req_search_key),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_position(rsp_position),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Ternary search over the shadow table. Each round probes one third in from
   // each end of [lo, hi], stops on the first probe that matches, and otherwise
   // keeps the left, right or middle part. A count above the table depth is
   // saturated, and an empty table finds nothing.
   function automatic lookup_result_type ternary_lookup(
         logic signed [sts_pkg::ValueW-1:0] key);
      lookup_result_type res;
      int lo;
      int hi;
      int third;
      int p1;
      int p2;
      logic signed [sts_pkg::ValueW-1:0] v1;
      logic signed [sts_pkg::ValueW-1:0] v2;
      res.found = 1'b0;
      res.position = '0;
      lo = 0;
      hi = (shadow_count > TableDepth ? TableDepth : shadow_count) - 1;
      while (lo <= hi) begin
         third = (hi - lo) / 3;
         p1 = lo + third;
         p2 = hi - third;
         v1 = shadow_table[p1];
         v2 = shadow_table[p2];
         if (key == v1) begin
            res.found = 1'b1;
            res.position = p1[sts_pkg::IndexW-1:0];
            return res;
         end
         if (key == v2) begin
            res.found = 1'b1;
            res.position = p2[sts_pkg::IndexW-1:0];
            return res;
         end
         if (key < v1) begin
            hi = p1 - 1;
         end else if (key > v2) begin
            lo = p2 + 1;
         end else begin
            lo = p1 + 1;
            hi = p2 - 1;
         end
      end
      return res;
   endfunction

   task automatic flag_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // Request side, sampled at the rising edge. A write beat updates the shadow
   // table at once; a search beat queues the result that it must produce.
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            if (req_kind == sts_pkg::KindWrite) begin
               shadow_table[req_write_index] = req_write_value;
            end else begin
               pending_lookups.push_back(ternary_lookup(req_search_key));
            end
         end
      end
   end

   // Driver. The payload only moves once the previous beat has gone through or
   // while valid is low, so a stalled beat stays put.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (request_beats.size() != 0 && (steady_run || $urandom_range(99) >= 9)) begin
            next_beat = request_beats.pop_front();
            req_valid <= 1'b1;
            req_kind <= next_beat.kind;
            req_write_index <= next_beat.write_index;
            req_write_value <= next_beat.write_value;
            req_search_key <= next_beat.search_key;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: random back-pressure, then a field by field check of each
   // result beat against the oldest outstanding search.
   always @(negedge clock) begin
      rsp_stall <= !reset && !steady_run && ($urandom_range(99) < 9);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            flag_mismatch("result beat with no search outstanding");
         end else begin
            expected_hit = pending_lookups.pop_front();
            if (rsp_found !== expected_hit.found) begin
               flag_mismatch($sformatf("found %b, expected %b",
                                       rsp_found, expected_hit.found));
            end
            if (rsp_position !== expected_hit.position) begin
               flag_mismatch($sformatf("position %0d, expected %0d",
                                       rsp_position, expected_hit.position));
            end
         end
      end
   end

   task automatic push_beat(logic kind, logic [sts_pkg::IndexW-1:0] idx,
                            logic signed [sts_pkg::ValueW-1:0] value,
                            logic signed [sts_pkg::ValueW-1:0] key);
      request_beat_type beat;
      beat.kind = kind;
      beat.write_index = idx;
      beat.write_value = value;
      beat.search_key = key;
      request_beats.push_back(beat);
      if (kind == sts_pkg::KindWrite) begin
         plan_table[idx] = value;
      end
   endtask

   // The unused fields of a search beat carry random bits; the DUT must ignore them.
   task automatic push_search(logic signed [sts_pkg::ValueW-1:0] key);
      logic [31:0] junk;
      junk = $urandom;
      push_beat(sts_pkg::KindSearch, junk[sts_pkg::IndexW-1:0], $urandom, key);
   endtask

   // Waits until every beat is taken and every result is in, then lets the
   // last write settle.
   task automatic wait_quiet();
      while (request_beats.size() != 0 || req_valid || pending_lookups.size() != 0) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_count(int value);
      wait_quiet();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value[sts_pkg::CountW-1:0];
      shadow_count = value;
      plan_count = value > TableDepth ? TableDepth : value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly searches for keys that sit in the live part of the table, so that
   // most searches hit; some near misses, extremes and random keys. About
   // one beat in eight is a write that keeps the order, and a few writes drop
   // a random value in and break it.
   task automatic queue_random_beats(int beats);
      int pick;
      int slot;
      int idx;
      longint lo_bound;
      longint hi_bound;
      longint rnd;
      for (int n = 0; n < beats; n++) begin
         pick = $urandom_range(99);
         slot = plan_count == 0 ? $urandom_range(TableDepth - 1)
                                : $urandom_range(plan_count - 1);
         idx = $urandom_range(1) ? slot : $urandom_range(TableDepth - 1);
         if (pick < 12) begin
            lo_bound = idx == 0 ? longint'(MinValue) : longint'(plan_table[idx - 1]);
            hi_bound = idx == TableDepth - 1 ? longint'(MaxValue)
                                             : longint'(plan_table[idx + 1]);
            rnd = $urandom;
            if (hi_bound > lo_bound) begin
               lo_bound = lo_bound + rnd % (hi_bound - lo_bound + 1);
            end
            push_beat(sts_pkg::KindWrite, idx[sts_pkg::IndexW-1:0],
                      lo_bound[sts_pkg::ValueW-1:0], $urandom);
         end else if (pick < 15) begin
            push_beat(sts_pkg::KindWrite, idx[sts_pkg::IndexW-1:0], $urandom, $urandom);
         end else if (pick < 70) begin
            push_search(plan_table[slot]);
         end else if (pick < 85) begin
            push_search($urandom_range(1) ? plan_table[slot] + 1 : plan_table[slot] - 1);
         end else if (pick < 95) begin
            case ($urandom_range(3))
               0: begin
                  push_search(MinValue);
               end
               1: begin
                  push_search(MaxValue);
               end
               2: begin
                  push_search('0);
               end
               default: begin
                  push_search(-1);
               end
            endcase
         end else begin
            push_search($urandom);
         end
      end
   endtask

   initial begin
      int phase_counts[$];
      longint acc;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table straight out of reset: nothing is found.
      push_search('0);
      push_search(MinValue);
      push_search(MaxValue);

      // Fill the whole table in ascending order, from the most negative value
      // at index 0 to the most positive at the top, with some duplicates.
      // Writes go in from the top index down. Every entry is defined after this,
      // so any count is safe to search.
      acc = longint'(MinValue);
      for (int i = 0; i < TableDepth; i++) begin
         if (i == TableDepth - 1) begin
            acc = longint'(MaxValue);
         end else if (i > 0) begin
            acc = acc + (($urandom_range(7) == 0) ? 0 : $urandom_range(8000000));
            if (acc > longint'(MaxValue)) begin
               acc = longint'(MaxValue);
            end
         end
         plan_table[i] = acc[sts_pkg::ValueW-1:0];
      end
      for (int i = TableDepth - 1; i >= 0; i--) begin
         push_beat(sts_pkg::KindWrite, i[sts_pkg::IndexW-1:0], plan_table[i], $urandom);
      end

      // Directed searches on the smallest tables, the full table and a count
      // above the depth, which must behave as the full table.
      set_count(1);
      push_search(plan_table[0]);
      push_search(MaxValue);
      push_search('0);
      set_count(2);
      push_search(plan_table[1]);
      push_search(plan_table[0]);
      set_count(3);
      push_search(plan_table[2]);
      push_search(plan_table[1] + 1);
      set_count(TableDepth);
      push_search(MinValue);
      push_search(MaxValue);
      push_search(plan_table[511]);
      push_search(plan_table[340] - 1);
      set_count(2047);
      push_search(MaxValue);
      push_search(plan_table[TableDepth - 2]);

      // Random phases, each under its own count. The full-table phase runs with
      // no idling on either side.
      phase_counts = '{4, 5, 9, 27, 80, 1024, 1025, 2047, 0, 300};
      repeat (4) begin
         phase_counts.push_back($urandom_range(1) ? $urandom_range(64) : $urandom_range(2047));
      end
      foreach (phase_counts[p]) begin
         set_count(phase_counts[p]);
         steady_run = (phase_counts[p] == TableDepth);
         queue_random_beats(BeatsPerPhase);
         wait_quiet();
         steady_run = 1'b0;
      end

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: the DUT stopped taking beats or giving results.");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
